// ===== src/cpal_pkg.sv =====
// cpal_pkg: shared types and sizes for the palette builder
// depends on nothing
package cpal_pkg;

  localparam int PALETTE_SIZE = 1024;
  localparam int SAMPLE_BITS  = 16;
  localparam int LOOKUP_SIZE  = 2 * PALETTE_SIZE;
  localparam int IDX_W        = $clog2(PALETTE_SIZE);
  localparam int CNT_W        = $clog2(PALETTE_SIZE + 1);
  localparam int POS_W        = $clog2(LOOKUP_SIZE);
  localparam int COLOR_W      = 48;
  localparam int QDEPTH       = 2;

  localparam logic REQ_LOOKUP = 1'b0;
  localparam logic REQ_READ   = 1'b1;

  typedef struct packed {
    logic                 req_type;
    logic [COLOR_W-1:0]   color;
    logic [9:0]           read_index;
  } cpal_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HASH,
    ST_PROBE,
    ST_CHECK,
    ST_READ,
    ST_OUT,
    ST_CLEAR
  } cpal_state_t;

endpackage

// ===== src/cpal_front.sv =====
// cpal_front: accepts requests, packs samples and queues them for the engine
// depends on cpal_pkg
module cpal_front import cpal_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            in_req_type,
  input  logic [15:0]     in_red,
  input  logic [15:0]     in_green,
  input  logic [15:0]     in_blue,
  input  logic [9:0]      in_read_index,
  output logic            q_valid,
  input  logic            q_ready,
  output cpal_req_t       q_req
);

  cpal_req_t            mem_r [QDEPTH];
  logic [0:0]           wp_r, rp_r;
  logic [1:0]           cnt_r;
  logic                 push, pop;
  cpal_req_t            req_in;
  logic [SAMPLE_BITS-1:0] r_m, g_m, b_m;

  // samples taken at their full SAMPLE_BITS width
  assign r_m = in_red[SAMPLE_BITS-1:0];
  assign g_m = in_green[SAMPLE_BITS-1:0];
  assign b_m = in_blue[SAMPLE_BITS-1:0];
  always_comb begin
    req_in.req_type   = in_req_type;
    req_in.color      = {16'(r_m), 16'(g_m), 16'(b_m)};
    req_in.read_index = in_read_index;
  end

  assign in_ready = (cnt_r != 2'(QDEPTH));
  assign q_valid  = (cnt_r != 2'd0);
  assign q_req    = mem_r[rp_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  // request queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= req_in;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'(QDEPTH)) else $error("queue overflow");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> cnt_r != 2'd0) else $error("pop from empty queue");
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop && $past(rst_n) |=> cnt_r == $past(cnt_r) + 2'd1)
    else $error("count not advanced");
`endif

endmodule

// ===== src/cpal_engine.sv =====
// cpal_engine: hashed probe, insert, palette read and result register
// depends on cpal_pkg
module cpal_engine import cpal_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  output logic              q_ready,
  input  cpal_req_t         q_req,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [9:0]        out_color_index,
  output logic              out_is_new,
  output logic              out_full_error,
  output logic [15:0]       out_entry_red,
  output logic [15:0]       out_entry_green,
  output logic [15:0]       out_entry_blue,
  output logic [10:0]       out_color_count
);

  // slot layout: valid bit, colour, palette index
  localparam int SLOT_W = 1 + COLOR_W + IDX_W;

  // memories
  logic [COLOR_W-1:0] pal_mem [PALETTE_SIZE];
  logic [SLOT_W-1:0]  lut_mem [LOOKUP_SIZE];

  cpal_state_t state_r, state_nxt;
  cpal_req_t   req_r;
  logic [CNT_W-1:0] count_r;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [POS_W:0]   probes_r, probes_nxt;
  logic [63:0]      prod_r;
  logic [63:0]      pp_ll_r, pp_lh_r, pp_hl_r;
  logic [SLOT_W-1:0] slot_rd_r;
  logic [COLOR_W-1:0] pal_rd_r;
  logic              rd_hit_r;
  logic              busy_r;
  logic [POS_W-1:0]  clr_r;

  logic [63:0] h_lo;
  logic [63:0] hx;
  logic        lut_we, pal_we, take, fin;
  logic [IDX_W-1:0] res_idx;
  logic        res_new, res_full;
  logic        load_req;
  logic        lut_wr;
  logic [POS_W-1:0]  lut_wa;
  logic [SLOT_W-1:0] lut_wd;

  assign q_ready  = (state_r == ST_IDLE);
  assign take     = q_valid && q_ready;

  // hash multiply split over 32-bit partial products, taken as the request enters
  always_ff @(posedge clk) begin
    if (load_req) begin
      pp_ll_r <= 64'(q_req.color[31:0]) * 64'h0000_0000_7F4A_7C15;
      pp_lh_r <= 64'(q_req.color[31:0]) * 64'h0000_0000_9E37_79B9;
      pp_hl_r <= 64'(q_req.color[47:32]) * 64'h0000_0000_7F4A_7C15;
    end
  end
  assign h_lo = pp_ll_r + {pp_lh_r[31:0], 32'd0} + {pp_hl_r[31:0], 32'd0};
  assign hx   = prod_r ^ (prod_r >> 29);

  // control
  always_comb begin
    state_nxt  = state_r;
    pos_nxt    = pos_r;
    probes_nxt = probes_r;
    lut_we     = 1'b0;
    pal_we     = 1'b0;
    fin        = 1'b0;
    res_idx    = '0;
    res_new    = 1'b0;
    res_full   = 1'b0;
    load_req   = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        if (clr_r == '1) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (take) begin
          load_req  = 1'b1;
          state_nxt = (q_req.req_type == REQ_READ) ? ST_READ : ST_HASH;
        end
      end
      ST_HASH: state_nxt = ST_PROBE;
      ST_PROBE: begin
        pos_nxt    = hx[POS_W-1:0];
        probes_nxt = '0;
        state_nxt  = ST_CHECK;
      end
      ST_CHECK: begin
        if (busy_r) begin
          state_nxt = ST_CHECK;
        end else if (!slot_rd_r[SLOT_W-1]) begin
          if (count_r >= CNT_W'(PALETTE_SIZE)) begin
            res_full = 1'b1;
          end else begin
            res_idx = count_r[IDX_W-1:0];
            res_new = 1'b1;
            lut_we  = 1'b1;
            pal_we  = 1'b1;
          end
          fin = 1'b1;
        end else if (slot_rd_r[SLOT_W-2:IDX_W] == req_r.color) begin
          res_idx = slot_rd_r[IDX_W-1:0];
          fin     = 1'b1;
        end else if (probes_r == (POS_W+1)'(LOOKUP_SIZE - 1)) begin
          res_full = 1'b1;
          fin      = 1'b1;
        end else begin
          pos_nxt    = pos_r + 1'b1;
          probes_nxt = probes_r + 1'b1;
        end
        if (fin) state_nxt = ST_OUT;
      end
      ST_READ: begin
        if (busy_r) state_nxt = ST_READ;
        else        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid || out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_CLEAR;
    else        state_r <= state_nxt;
  end

  // datapath registers; busy_r marks the cycle the memory read is in flight
  always_ff @(posedge clk) begin
    if (load_req) req_r <= q_req;
    if (state_r == ST_HASH) prod_r <= h_lo;
    pos_r    <= pos_nxt;
    probes_r <= probes_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) busy_r <= 1'b0;
    else busy_r <= (state_r == ST_PROBE) || (state_r == ST_CHECK && state_nxt == ST_CHECK
                   && !busy_r) || (state_r == ST_IDLE && take && q_req.req_type == REQ_READ);
  end

  // clearing pass over the lookup slots after reset
  always_ff @(posedge clk) begin
    if (!rst_n) clr_r <= '0;
    else if (state_r == ST_CLEAR) clr_r <= clr_r + 1'b1;
  end

  // lookup write port: empty slots while clearing, else the insert
  always_comb begin
    if (state_r == ST_CLEAR) begin
      lut_wr = 1'b1;
      lut_wa = clr_r;
      lut_wd = '0;
    end else begin
      lut_wr = lut_we;
      lut_wa = pos_r;
      lut_wd = {1'b1, req_r.color, count_r[IDX_W-1:0]};
    end
  end

  // lookup memory, read at pos_nxt
  always_ff @(posedge clk) begin
    if (lut_wr) lut_mem[lut_wa] <= lut_wd;
    slot_rd_r <= lut_mem[pos_nxt];
  end

  // palette memory
  always_ff @(posedge clk) begin
    if (pal_we) pal_mem[count_r[IDX_W-1:0]] <= req_r.color;
    pal_rd_r <= pal_mem[req_r.read_index[IDX_W-1:0]];
    rd_hit_r <= (CNT_W'(req_r.read_index) < count_r);
  end

  // colour count
  always_ff @(posedge clk) begin
    if (!rst_n) count_r <= '0;
    else if (pal_we) count_r <= count_r + 1'b1;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (fin || (state_r == ST_READ && !busy_r)) out_valid <= 1'b1;
    end
    if (fin) begin
      out_color_index <= 10'(res_idx);
      out_is_new      <= res_new;
      out_full_error  <= res_full;
      out_entry_red   <= '0;
      out_entry_green <= '0;
      out_entry_blue  <= '0;
      out_color_count <= 11'(count_r + CNT_W'(pal_we));
    end else if (state_r == ST_READ && !busy_r) begin
      out_color_index <= req_r.read_index;
      out_is_new      <= 1'b0;
      out_full_error  <= 1'b0;
      out_entry_red   <= rd_hit_r ? pal_rd_r[47:32] : 16'd0;
      out_entry_green <= rd_hit_r ? pal_rd_r[31:16] : 16'd0;
      out_entry_blue  <= rd_hit_r ? pal_rd_r[15:0]  : 16'd0;
      out_color_count <= 11'(count_r);
    end
  end

`ifndef ASSERT_OFF
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(PALETTE_SIZE)) else $error("colour count overrun");
  a_new_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_is_new && out_full_error)) else $error("new and full together");
  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    pal_we |=> count_r == $past(count_r) + 1'b1) else $error("insert lost");
`endif

endmodule

// ===== src/color_palette_find_or_add.sv =====
// color_palette_find_or_add: top level, request queue front and probe engine
// depends on cpal_pkg, cpal_front, cpal_engine
//
//  channel | handshake            | payload
//  in_     | in_valid / in_ready  | req_type, red, green, blue, read_index
//  out_    | out_valid / out_ready| color_index, is_new, full_error, entry_*, color_count
//
// a lookup result passes the hash, probe and check states, with a further slot read per extra
// probe of the linear-probe table; a palette read result passes the read state
// the engine takes its next request the cycle after a result is taken, so it holds one
// request at a time, lookup or read; the single-port probe loop sets the rate
// after reset a clearing pass empties all 2048 lookup slots before any request
// a two-entry queue lets requests be taken while the engine works or output stalls
module color_palette_find_or_add import cpal_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_req_type,
  input  logic [15:0] in_red,
  input  logic [15:0] in_green,
  input  logic [15:0] in_blue,
  input  logic [9:0]  in_read_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [9:0]  out_color_index,
  output logic        out_is_new,
  output logic        out_full_error,
  output logic [15:0] out_entry_red,
  output logic [15:0] out_entry_green,
  output logic [15:0] out_entry_blue,
  output logic [10:0] out_color_count
);

  logic      q_valid, q_ready;
  cpal_req_t q_req;

  // request queue
  cpal_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_req_type, .in_red, .in_green,
    .in_blue, .in_read_index, .q_valid, .q_ready, .q_req
  );

  // probe and palette engine
  cpal_engine u_engine (
    .clk, .rst_n, .q_valid, .q_ready, .q_req, .out_valid, .out_ready,
    .out_color_index, .out_is_new, .out_full_error, .out_entry_red,
    .out_entry_green, .out_entry_blue, .out_color_count
  );

endmodule
